// ----- rtl/ledm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ledm_pkg: shared types and constants of the LED matrix scan driver
// Pixel layout, request codes, register map and the PWM compare helper.
// ----------------------------------------------------------------------------
package ledm_pkg;

   // Request codes carried on the func field
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_SHIFT = 1'b1;

   // Register map: one 32-bit register per word, index taken from paddr[2]
   localparam int        CSR_ADDR_W  = 3;
   localparam int        CSR_DATA_W  = 32;
   localparam logic [0:0] REG_DISPLAY_ENABLE = 1'b0;

   // Stored pixel: red in the top nibble, blue in the bottom one
   localparam int COMP_W = 4;
   localparam int PIX_W  = 3 * COMP_W;
   localparam int RGB_W  = 3;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } pixel_type;

   // A colour line is lit while its intensity exceeds the subframe level
   function automatic logic [RGB_W-1:0] rgb_lit(input pixel_type pix,
                                                input logic [7:0] level);
      logic [RGB_W-1:0] bits;
      bits[2] = (8'(pix.red)   > level);
      bits[1] = (8'(pix.green) > level);
      bits[0] = (8'(pix.blue)  > level);
      return bits;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/led_matrix_scan_driver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_scan_driver: RGB LED panel scan and PWM driver
// Usage:
//   Requests arrive on req_* (valid/stall). A write request stores one
//   pixel if it lies in the panel and returns one all-zero response. A
//   shift request returns one column slot of the 2*PANEL_SIZE shift chain
//   with both data lines, row address, latch, subframe and frame_done;
//   while display_enable is 0 a shift request is taken but gives no
//   response and the scan holds. Responses leave on rsp_* (valid/stall);
//   display_enable sits at csr address 0.
//   A request passes the pixel RAM read register, with the slot beside
//   it, then the response register. One request is taken every cycle
//   while req_stall is low; the rate is set by the two-port pixel RAM,
//   read once per shift request.
//   Reset: counters return to zero, display_enable to 1, and a clearing
//   pass writes zero to all PANEL_SIZE*PANEL_SIZE pixels with req_stall
//   held high; csr writes are taken meanwhile.
//   Stall: a stalled response holds; the RAM stage behind it holds too,
//   and req_stall rises once both stages are full and rsp_stall is high.
// ----------------------------------------------------------------------------
module led_matrix_scan_driver #(
   parameter int PANEL_SIZE = 32,
   parameter int SCAN_ROWS  = 8,
   parameter int PWM_LEVELS = 15
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_func,
   input  wire logic [4:0]                         req_pixel_x,
   input  wire logic [4:0]                         req_pixel_y,
   input  wire logic [ledm_pkg::COMP_W-1:0]        req_red,
   input  wire logic [ledm_pkg::COMP_W-1:0]        req_green,
   input  wire logic [ledm_pkg::COMP_W-1:0]        req_blue,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_shift_valid,
   output logic      [ledm_pkg::RGB_W-1:0]         rsp_upper_rgb,
   output logic      [ledm_pkg::RGB_W-1:0]         rsp_lower_rgb,
   output logic      [5:0]                         rsp_column_slot,
   output logic      [2:0]                         rsp_row_address,
   output logic                                    rsp_latch,
   output logic      [3:0]                         rsp_subframe,
   output logic                                    rsp_frame_done,
   // configuration port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [ledm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [ledm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [ledm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                    csr_pready
);

   import ledm_pkg::*;

   localparam int CHAIN_LEN = 2 * PANEL_SIZE;
   localparam int COL_W     = $clog2(CHAIN_LEN);
   localparam int ROW_W     = $clog2(SCAN_ROWS);
   localparam int SF_W      = $clog2(PWM_LEVELS + 1);
   localparam int Y_W       = $clog2(4 * SCAN_ROWS);
   localparam int DEPTH     = PANEL_SIZE * PANEL_SIZE;
   localparam int ADDR_W    = $clog2(DEPTH);

   // Scan slot carried alongside the RAM read
   typedef struct packed {
      logic             shift;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [SF_W-1:0]  sf;
      logic             latch;
      logic             done;
      logic             up_dark;
      logic             lo_dark;
   } slot_type;

   logic              enable_ff, enable_in;
   logic              clr_ff, clr_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SF_W-1:0]   sf_ff, sf_in;
   logic              s1_vld_ff, s1_vld_in;
   slot_type          s1_ff, s1_in;
   logic              out_vld_ff, out_vld_in;

   logic              req_take, take_write, take_shift, out_load, s1_free;
   logic              last_col, last_row;
   logic [COL_W-1:0]  x_sel;
   logic [Y_W-1:0]    y_up, y_lo;
   logic              up_dark, lo_dark;
   logic [ADDR_W-1:0] rd_addr_up, rd_addr_lo;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [PIX_W-1:0]  wr_data;
   logic [PIX_W-1:0]  rd_data_up, rd_data_lo;
   logic              csr_wr;

   // Handshake
   always_comb begin
      out_load   = s1_vld_ff && (!out_vld_ff || !rsp_stall);
      s1_free    = !s1_vld_ff || out_load;
      req_stall  = clr_ff || !s1_free;
      req_take   = req_valid && !req_stall;
      take_write = req_take && (req_func == FUNC_WRITE);
      take_shift = req_take && (req_func == FUNC_SHIFT) && enable_ff;
   end

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == REG_DISPLAY_ENABLE);
   assign enable_in = csr_wr ? csr_pwdata[0] : enable_ff;
   assign csr_prdata = (csr_paddr[2] == REG_DISPLAY_ENABLE)
                       ? {{(CSR_DATA_W-1){1'b0}}, enable_ff} : '0;

   // Pixel coordinates of the current slot
   always_comb begin
      if (32'(col_ff) < PANEL_SIZE) begin
         x_sel = col_ff;
         y_up  = Y_W'(row_ff);
      end else begin
         x_sel = col_ff - COL_W'(PANEL_SIZE);
         y_up  = Y_W'(row_ff) + Y_W'(2 * SCAN_ROWS);
      end
      y_lo    = y_up + Y_W'(SCAN_ROWS);
      up_dark = (32'(y_up) >= PANEL_SIZE);
      lo_dark = (32'(y_lo) >= PANEL_SIZE);
      rd_addr_up = up_dark ? '0 : ADDR_W'(32'(y_up) * PANEL_SIZE + 32'(x_sel));
      rd_addr_lo = lo_dark ? '0 : ADDR_W'(32'(y_lo) * PANEL_SIZE + 32'(x_sel));
   end

   // Scan counters
   always_comb begin
      last_col = (32'(col_ff) == CHAIN_LEN - 1);
      last_row = (32'(row_ff) == SCAN_ROWS - 1);
      col_in   = col_ff;
      row_in   = row_ff;
      sf_in    = sf_ff;
      if (take_shift) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in = '0;
               sf_in  = (32'(sf_ff) == PWM_LEVELS - 1) ? '0 : sf_ff + SF_W'(1);
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // Clearing pass after reset
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (32'(clr_addr_ff) == DEPTH - 1) begin
            clr_in = 1'b0;
         end
      end
   end

   // Pixel write port: clearing pass or an in-panel write request
   always_comb begin
      if (clr_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = take_write && (32'(req_pixel_x) < PANEL_SIZE)
                   && (32'(req_pixel_y) < PANEL_SIZE);
         wr_addr = ADDR_W'(32'(req_pixel_y) * PANEL_SIZE + 32'(req_pixel_x));
         wr_data = {req_red, req_green, req_blue};
      end
   end

   ledm_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_pixel_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (take_shift),
      .rd_addr_a (rd_addr_up),
      .rd_addr_b (rd_addr_lo),
      .rd_data_a (rd_data_up),
      .rd_data_b (rd_data_lo)
   );

   // Stage 1: slot beside the RAM read
   always_comb begin
      s1_vld_in = s1_free ? (take_write || take_shift) : s1_vld_ff;
      s1_in     = s1_ff;
      if (s1_free) begin
         s1_in.shift   = take_shift;
         s1_in.col     = col_ff;
         s1_in.row     = row_ff;
         s1_in.sf      = sf_ff;
         s1_in.latch   = last_col;
         s1_in.done    = last_col && last_row;
         s1_in.up_dark = up_dark;
         s1_in.lo_dark = lo_dark;
      end
      out_vld_in = out_load ? 1'b1 : (out_vld_ff && rsp_stall);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b1;
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         sf_ff       <= '0;
         s1_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         enable_ff   <= enable_in;
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         sf_ff       <= sf_in;
         s1_vld_ff   <= s1_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (out_load) begin
         rsp_shift_valid <= s1_ff.shift;
         rsp_upper_rgb   <= (s1_ff.shift && !s1_ff.up_dark)
                            ? rgb_lit(pixel_type'(rd_data_up), 8'(s1_ff.sf)) : '0;
         rsp_lower_rgb   <= (s1_ff.shift && !s1_ff.lo_dark)
                            ? rgb_lit(pixel_type'(rd_data_lo), 8'(s1_ff.sf)) : '0;
         rsp_column_slot <= s1_ff.shift ? 6'(s1_ff.col) : '0;
         rsp_row_address <= s1_ff.shift ? 3'(s1_ff.row) : '0;
         rsp_latch       <= s1_ff.shift && s1_ff.latch;
         rsp_subframe    <= s1_ff.shift ? 4'(s1_ff.sf) : '0;
         rsp_frame_done  <= s1_ff.shift && s1_ff.done;
      end
   end

   assign rsp_valid = out_vld_ff;

endmodule
`default_nettype wire

// ----- rtl/ledm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ledm_ram: generic RAM, one write port and two registered read ports
// Read data registers load only when rd_en is high and hold otherwise.
// ----------------------------------------------------------------------------
module ledm_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Two read ports with registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/ledm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ledm_checker: port-level checks of the LED matrix scan driver
// Watches the response channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ledm_checker #(
   parameter int PANEL_SIZE = 32
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_shift_valid,
   input wire logic [2:0] rsp_upper_rgb,
   input wire logic [2:0] rsp_lower_rgb,
   input wire logic [5:0] rsp_column_slot,
   input wire logic [2:0] rsp_row_address,
   input wire logic       rsp_latch,
   input wire logic [3:0] rsp_subframe,
   input wire logic       rsp_frame_done
);

   // No response straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_column_slot)
         && $stable(rsp_shift_valid) && $stable(rsp_upper_rgb))
      else $error("stalled response changed");

   // Latch only on the last slot of the chain
   a_latch_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_latch |-> rsp_shift_valid
         && (rsp_column_slot == 6'(2 * PANEL_SIZE - 1)))
      else $error("latch away from last column slot");

   // End of subframe only together with latch
   a_done_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_latch)
      else $error("frame_done without latch");

   // Write responses carry nothing
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_shift_valid |-> (rsp_upper_rgb == '0)
         && (rsp_lower_rgb == '0) && (rsp_column_slot == '0)
         && (rsp_row_address == '0) && (rsp_subframe == '0))
      else $error("write response not all zero");

endmodule

bind led_matrix_scan_driver ledm_checker #(
   .PANEL_SIZE (PANEL_SIZE)
) u_ledm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_shift_valid (rsp_shift_valid),
   .rsp_upper_rgb   (rsp_upper_rgb),
   .rsp_lower_rgb   (rsp_lower_rgb),
   .rsp_column_slot (rsp_column_slot),
   .rsp_row_address (rsp_row_address),
   .rsp_latch       (rsp_latch),
   .rsp_subframe    (rsp_subframe),
   .rsp_frame_done  (rsp_frame_done)
);
`default_nettype wire
